// ----- src/tlb_fifo_lookup_insert_top_assert.svh -----
// ----------------------------------------------------------------------------
// tlb_fifo_lookup_insert_top_assert.svh
// assertion macros used by the translation buffer rtl
// ----------------------------------------------------------------------------
`ifndef TLB_FIFO_LOOKUP_INSERT_TOP_ASSERT_SVH
`define TLB_FIFO_LOOKUP_INSERT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// check a property, skipped while reset is high
`define TLBFLI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every rising edge, reset included
`define TLBFLI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TLBFLI_ASSERT(lbl, clk, rst, prop, msg)
`define TLBFLI_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- src/tlbfli_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbfli_pkg
// types and constants of the fully associative translation buffer
// ----------------------------------------------------------------------------
package tlbfli_pkg;

   // buffer geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PAGE_W  = 20;
   localparam int FRAME_W = 20;
   localparam int CNT_W   = 32;

   // operation codes
   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_PROBE  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // request word
   typedef struct packed {
      logic [1:0]         func;
      logic [PAGE_W-1:0]  vpage;
      logic               write_access;
      logic [FRAME_W-1:0] frame_in;
      logic               readonly_in;
   } req_type;

   // response word
   typedef struct packed {
      logic               hit;
      logic               present;
      logic [FRAME_W-1:0] frame_out;
      logic [CNT_W-1:0]   hit_total;
      logic [CNT_W-1:0]   miss_total;
      logic [CNT_W-1:0]   change_total;
   } rsp_type;

   // one stored translation
   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
      logic               readonly;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- src/tlb_fifo_lookup_insert_top.sv -----
// ----------------------------------------------------------------------------
// tlb_fifo_lookup_insert_top
// fully associative translation buffer, fifo replacement, entry ram scan
// ----------------------------------------------------------------------------
// Usage: a request word on req_* carries an operation (lookup, insert,
// probe), a page number, the access type and, for inserts, the frame and
// read-only flag. Every request gives exactly one response word on rsp_*
// with hit, present, frame and the running hit, miss and insert totals.
// Entries live in a one-port-read ram; valid bits are flip-flops.
// Order: an insert or an unused code goes from acceptance straight to the
// emit state. A lookup or probe reads the ram one entry per cycle from
// index 0 and stops at the first valid match or after the last entry, so
// its response comes later the higher the matching index. The emit state
// moves the result to the output register once that is free. One request
// is in flight at a time; the next one is taken once the previous response
// has been moved to the output register.
// Reset clears all valid bits, the replace pointer, the totals and the
// handshake state; no ram clearing pass is needed.
// A stalled receiver holds the response in the output register; a finished
// result then waits in the work registers and blocks new requests.
// ----------------------------------------------------------------------------
`include "tlb_fifo_lookup_insert_top_assert.svh"

module tlb_fifo_lookup_insert_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tlbfli_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tlbfli_pkg::rsp_type rsp_data
);

   import tlbfli_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic [CNT_W-1:0]   ins_cnt_ff, ins_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // work registers of the request in flight
   func_type           op_ff, op_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic               wr_ff, wr_in;
   logic               res_hit_ff, res_hit_in;
   logic               res_present_ff, res_present_in;
   logic [FRAME_W-1:0] res_frame_ff, res_frame_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // ram ports
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   entry_type          ram_rd_data;
   logic [ENTRY_W-1:0] ram_rd_bits;

   logic               req_fire;
   logic               scan_match;
   logic               scan_last;
   logic               slot_free;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign ram_rd_data = entry_type'(ram_rd_bits);
   assign scan_match  = valid_ff[idx_ff] && (ram_rd_data.page == page_ff);
   assign scan_last   = (idx_ff == IDX_W'(ENTRIES - 1));
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   // insert writes the fifo slot directly at acceptance
   assign ram_wr_en   = req_fire && (func_type'(req_data.func) == FUNC_INSERT);
   assign ram_wr_addr = ptr_ff;
   assign ram_wr_data = '{page:     req_data.vpage,
                          frame:    req_data.frame_in,
                          readonly: req_data.readonly_in};

   // scan read address: entry 0 on acceptance, then the next one
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      if (state_ff == ST_IDLE) begin
         ram_rd_en = req_fire;
      end else if (state_ff == ST_SCAN) begin
         ram_rd_en   = !scan_match && !scan_last;
         ram_rd_addr = idx_ff + 1'b1;
      end
   end

   tlbfli_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   // sequencer and work state
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      ptr_in         = ptr_ff;
      idx_in         = idx_ff;
      hit_cnt_in     = hit_cnt_ff;
      miss_cnt_in    = miss_cnt_ff;
      ins_cnt_in     = ins_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      op_in          = op_ff;
      page_in        = page_ff;
      wr_in          = wr_ff;
      res_hit_in     = res_hit_ff;
      res_present_in = res_present_ff;
      res_frame_in   = res_frame_ff;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in          = func_type'(req_data.func);
               page_in        = req_data.vpage;
               wr_in          = req_data.write_access;
               res_hit_in     = 1'b0;
               res_present_in = 1'b0;
               res_frame_in   = '0;
               idx_in         = '0;
               case (func_type'(req_data.func))
                  FUNC_LOOKUP, FUNC_PROBE: begin
                     state_in = ST_SCAN;
                  end
                  FUNC_INSERT: begin
                     valid_in[ptr_ff] = 1'b1;
                     ptr_in   = (ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
                     state_in = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // compare the entry read last cycle, first match wins
            if (scan_match) begin
               res_present_in = 1'b1;
               if (op_ff == FUNC_LOOKUP && (!wr_ff || !ram_rd_data.readonly)) begin
                  res_hit_in   = 1'b1;
                  res_frame_in = ram_rd_data.frame;
               end
               state_in = ST_EMIT;
            end else if (scan_last) begin
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // count and move the result to the output register
            if (slot_free) begin
               case (op_ff)
                  FUNC_LOOKUP: begin
                     if (res_hit_ff) begin
                        hit_cnt_in = hit_cnt_ff + 1'b1;
                     end else begin
                        miss_cnt_in = miss_cnt_ff + 1'b1;
                     end
                  end
                  FUNC_INSERT: begin
                     ins_cnt_in = ins_cnt_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.hit          = res_hit_ff;
               rsp_data_in.present      = res_present_ff;
               rsp_data_in.frame_out    = res_frame_ff;
               rsp_data_in.hit_total    = hit_cnt_in;
               rsp_data_in.miss_total   = miss_cnt_in;
               rsp_data_in.change_total = ins_cnt_in;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         ins_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         idx_ff       <= idx_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         ins_cnt_ff   <= ins_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      page_ff        <= page_in;
      wr_ff          <= wr_in;
      res_hit_ff     <= res_hit_in;
      res_present_ff <= res_present_in;
      res_frame_ff   <= res_frame_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `TLBFLI_ASSERT(a_hit_needs_present, clock, reset,
      rsp_valid_ff && rsp_data_ff.hit |-> rsp_data_ff.present,
      "hit reported without a present entry")
   `TLBFLI_ASSERT(a_insert_sets_valid, clock, reset,
      req_fire && func_type'(req_data.func) == FUNC_INSERT |=> valid_ff[$past(ptr_ff)],
      "inserted slot not marked valid")
   `TLBFLI_ASSERT(a_one_counter_moves, clock, reset,
      !$past(reset) && !$stable(hit_cnt_ff) |-> $stable(miss_cnt_ff) && $stable(ins_cnt_ff),
      "more than one total changed in a cycle")
   `TLBFLI_ASSERT(a_scan_in_range, clock, reset,
      state_ff == ST_SCAN |-> idx_ff <= IDX_W'(ENTRIES - 1),
      "scan index beyond the last entry")
   `TLBFLI_ASSERT(a_emit_holds_full, clock, reset,
      state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready |=> state_ff == ST_EMIT,
      "result moved while the output register was full")

endmodule

// ----- src/tlbfli_ram.sv -----
// ----------------------------------------------------------------------------
// tlbfli_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tlbfli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- dv/tlb_fifo_lookup_insert_top_checker.sv -----
// ----------------------------------------------------------------------------
// tlb_fifo_lookup_insert_top_checker
// Watches the request and response channels of the translation buffer. It
// keeps its own copy of the entry table, the fifo replace pointer and the
// hit, miss and insert totals, predicts the response word of every accepted
// request and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tlb_fifo_lookup_insert_top_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  tlbfli_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  tlbfli_pkg::rsp_type rsp_data,
   output int                  fail_count,
   output int                  open_count,
   output int                  result_count
);

   import tlbfli_pkg::*;

   // shadow translation table
   logic [PAGE_W-1:0]  shadow_page  [ENTRIES];
   logic [FRAME_W-1:0] shadow_frame [ENTRIES];
   bit                 shadow_ro    [ENTRIES];
   bit                 shadow_valid [ENTRIES];
   int                 fill_ptr;
   logic [CNT_W-1:0]   hit_sum;
   logic [CNT_W-1:0]   miss_sum;
   logic [CNT_W-1:0]   insert_sum;

   // translations still owed by the block, oldest first
   rsp_type pending_translations[$];
   rsp_type oldest;

   // lowest valid index holding the page, -1 when absent
   function automatic int find_page(logic [PAGE_W-1:0] page);
      for (int i = 0; i < ENTRIES; i++) begin
         if (shadow_valid[i] && shadow_page[i] == page) return i;
      end
      return -1;
   endfunction

   // apply one request word to the shadow table and build its response
   function automatic rsp_type translate(req_type w);
      rsp_type r;
      int      idx;
      r = '0;
      case (w.func)
         FUNC_LOOKUP: begin
            idx = find_page(w.vpage);
            if (idx >= 0) begin
               r.present = 1'b1;
               // writes to a read-only entry are refused
               if (!w.write_access || !shadow_ro[idx]) begin
                  r.hit       = 1'b1;
                  r.frame_out = shadow_frame[idx];
               end
            end
            if (r.hit) hit_sum++;
            else miss_sum++;
         end
         FUNC_INSERT: begin
            shadow_page[fill_ptr]  = w.vpage;
            shadow_frame[fill_ptr] = w.frame_in;
            shadow_ro[fill_ptr]    = w.readonly_in;
            shadow_valid[fill_ptr] = 1'b1;
            fill_ptr = (fill_ptr + 1) % ENTRIES;
            insert_sum++;
         end
         FUNC_PROBE: begin
            if (find_page(w.vpage) >= 0) r.present = 1'b1;
         end
         default: ;
      endcase
      r.hit_total    = hit_sum;
      r.miss_total   = miss_sum;
      r.change_total = insert_sum;
      return r;
   endfunction

   // one field compare
   task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
         fill_ptr   = 0;
         hit_sum    = '0;
         miss_sum   = '0;
         insert_sum = '0;
         pending_translations.delete();
      end else begin
         // response first: it always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (pending_translations.size() == 0) begin
               $error("response word %0h with no expectation waiting", rsp_data);
               fail_count++;
            end else begin
               oldest = pending_translations.pop_front();
               check_field("hit", oldest.hit, rsp_data.hit);
               check_field("present", oldest.present, rsp_data.present);
               check_field("frame_out", oldest.frame_out, rsp_data.frame_out);
               check_field("hit_total", oldest.hit_total, rsp_data.hit_total);
               check_field("miss_total", oldest.miss_total, rsp_data.miss_total);
               check_field("change_total", oldest.change_total, rsp_data.change_total);
               result_count++;
            end
         end
         if (req_valid && req_ready) pending_translations.push_back(translate(req_data));
      end
      open_count = pending_translations.size();
   end

endmodule

// ----- dv/tlb_fifo_lookup_insert_top_tb.sv -----
// ----------------------------------------------------------------------------
// tlb_fifo_lookup_insert_top_tb
// Drives lookup, insert, probe and unused request words into the translation
// buffer: a directed opening on the empty table, read-only refusals,
// duplicate pages and pointer wrap, then random traffic over a small page
// pool with random gaps on both channels, a long response hold-off and
// drain pauses. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tlb_fifo_lookup_insert_top_tb;

   import tlbfli_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int RESET_TICKS = 7;
   localparam int POOL_SIZE   = 24;
   localparam int PHASES      = 5;
   localparam int PHASE_WORDS = 284;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 2 * (ENTRIES + 2) + 4;
   localparam int STALL_LIMIT = 5000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int open_count;
   int result_count;

   // stimulus state
   logic [PAGE_W-1:0] page_pool [POOL_SIZE];
   int unsigned       op_seen [4];
   bit                quiet_phase  = 1'b0;
   bit                hold_request = 1'b0;
   int                hold_left    = 0;
   int                stall_left   = 0;
   int                idle_ticks   = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   tlb_fifo_lookup_insert_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tlb_fifo_lookup_insert_top_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .open_count   (open_count),
      .result_count (result_count)
   );

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_word(func_type op, logic [PAGE_W-1:0] page,
                                         logic wr, logic [FRAME_W-1:0] frame, logic ro);
      req_type w;
      w.func         = op;
      w.vpage        = page;
      w.write_access = wr;
      w.frame_in     = frame;
      w.readonly_in  = ro;
      return w;
   endfunction

   // random word, pages mostly from the pool so hits and duplicates happen
   function automatic req_type random_word();
      req_type w;
      int      r;
      if ($urandom_range(0, 99) < 85) w.vpage = page_pool[$urandom_range(0, POOL_SIZE - 1)];
      else w.vpage = PAGE_W'($urandom);
      w.write_access = 1'($urandom);
      w.frame_in     = FRAME_W'($urandom);
      w.readonly_in  = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 45) w.func = FUNC_LOOKUP;
      else if (r < 75) w.func = FUNC_INSERT;
      else if (r < 95) w.func = FUNC_PROBE;
      else w.func = FUNC_NONE;
      return w;
   endfunction

   // offer one word at a falling edge and hold it until accepted
   task automatic send_word(input req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      op_seen[w.func]++;
      @(negedge clock);
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // pause the sender until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (open_count != 0) @(negedge clock);
   endtask

   task automatic send_gapped(input req_type w);
      if (!quiet_phase) idle_for(pick_gap());
      send_word(w);
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ready   <= 1'b0;
         end else if (quiet_phase) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_ticks <= 0;
      end else if (idle_ticks + 1 >= STALL_LIMIT) begin
         $display("timeout after %0d cycles with no accepted word", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_ticks <= idle_ticks + 1;
      end
   end

   // stimulus and verdict
   initial begin
      foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom);
      page_pool[0]             = '0;
      page_pool[POOL_SIZE - 1] = '1;

      repeat (RESET_TICKS) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, unused code, extremes of page and frame
      send_gapped(make_word(FUNC_LOOKUP, '0, 1'b0, '0, 1'b0));
      send_gapped(make_word(FUNC_PROBE, '1, 1'b1, '1, 1'b1));
      send_gapped(make_word(FUNC_NONE, '1, 1'b1, '1, 1'b1));
      send_gapped(make_word(FUNC_INSERT, '0, 1'b0, '1, 1'b1));
      send_gapped(make_word(FUNC_INSERT, '1, 1'b1, '0, 1'b0));
      // read allowed, write refused on the read-only entry
      send_gapped(make_word(FUNC_LOOKUP, '0, 1'b0, '0, 1'b0));
      send_gapped(make_word(FUNC_LOOKUP, '0, 1'b1, '0, 1'b0));
      send_gapped(make_word(FUNC_LOOKUP, '1, 1'b1, '1, 1'b1));
      send_gapped(make_word(FUNC_PROBE, '0, 1'b0, '0, 1'b0));
      // duplicate page: the lower read-only copy still answers
      send_gapped(make_word(FUNC_INSERT, '0, 1'b0, 20'h12345, 1'b0));
      send_gapped(make_word(FUNC_LOOKUP, '0, 1'b1, '0, 1'b0));
      // fill up and wrap the replace pointer over the oldest entry
      for (int i = 0; i < 14; i++) begin
         send_gapped(make_word(FUNC_INSERT, PAGE_W'(20'h100 + i), 1'b0,
                               FRAME_W'(20'hF0000 + i), 1'(i)));
      end
      send_gapped(make_word(FUNC_LOOKUP, '0, 1'b1, '0, 1'b0));
      send_gapped(make_word(FUNC_LOOKUP, 20'h10C, 1'b0, '0, 1'b0));
      send_gapped(make_word(FUNC_PROBE, 20'hABCDE, 1'b0, '0, 1'b0));
      drain();

      // random phases; the middle one runs without gaps under a long hold-off
      for (int phase = 0; phase < PHASES; phase++) begin
         quiet_phase = (phase == 2);
         if (phase == 2) hold_request = 1'b1;
         for (int n = 0; n < PHASE_WORDS; n++) send_gapped(random_word());
         drain();
         for (int k = 1; k < POOL_SIZE - 1; k += 3) page_pool[k] = PAGE_W'($urandom);
      end
      quiet_phase = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d lookups, %0d inserts, %0d probes, %0d unused codes",
               op_seen[FUNC_LOOKUP], op_seen[FUNC_INSERT], op_seen[FUNC_PROBE],
               op_seen[FUNC_NONE]);
      $display("%0d response words compared, including a %0d-cycle response hold-off",
               result_count, HOLD_CYCLES);
      if (fail_count == 0 && open_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
